// ===== hw/rtl/tbt_pkg.sv =====
package tbt_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int LVL_W       = 24;
  localparam int TAG_W       = 8;
  localparam int ST_W        = 3;
  localparam int CLS_W       = 2;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int NUM_REGS    = 6;

  localparam logic [CLS_W-1:0] CLASS_INVALID = 2'd3;
  localparam logic [CLS_W-1:0] CLASS_LAST    = 2'd2;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic [ST_W-1:0] ST_GRANTED     = 3'd0;
  localparam logic [ST_W-1:0] ST_QUEUED      = 3'd1;
  localparam logic [ST_W-1:0] ST_UNTHROTTLED = 3'd2;
  localparam logic [ST_W-1:0] ST_SLIPPED     = 3'd3;
  localparam logic [ST_W-1:0] ST_RELEASED    = 3'd4;

  typedef struct packed {
    logic             command;
    logic [CLS_W-1:0] op_class;
    logic [LVL_W-1:0] tokens_wanted;
    logic [TAG_W-1:0] request_tag;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CLS_W-1:0] result_class;
    logic [TAG_W-1:0] result_tag;
    logic [LVL_W-1:0] tokens_left;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [NUM_CLASSES-1:0][LVL_W-1:0] rate;
    logic [NUM_CLASSES-1:0][LVL_W-1:0] lvl_max;
    logic [NUM_CLASSES-1:0]            clr;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] tokens;
  } wait_entry_t;

  typedef struct packed {
    logic [LVL_W:0] a;
    logic [LVL_W:0] b;
    logic           sub;
  } alu_op_t;

  typedef struct packed {
    logic [LVL_W:0] res;
    logic           borrow;
  } alu_res_t;

endpackage

// ===== hw/rtl/tbt_alu.sv =====
module tbt_alu
  import tbt_pkg::*;
(
  input  alu_op_t  op,
  output alu_res_t res
);

  logic [LVL_W+1:0] ext;

  always_comb begin
    if (op.sub) begin
      ext = {1'b0, op.a} - {1'b0, op.b};
    end else begin
      ext = {1'b0, op.a} + {1'b0, op.b};
    end
    res.res    = ext[LVL_W:0];
    res.borrow = ext[LVL_W+1];
  end

endmodule

// ===== hw/rtl/tbt_regs.sv =====
module tbt_regs
  import tbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam logic [2:0] REG_LAST = 3'(NUM_REGS - 1);

  logic [NUM_CLASSES-1:0][LVL_W-1:0] rate;
  logic [NUM_CLASSES-1:0][LVL_W-1:0] lvl_max;
  logic [2:0]       idx;
  logic [CLS_W-1:0] wcls;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wcls   = idx[2:1];
  assign wr     = psel && penable && pwrite && (idx <= REG_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate    <= '0;
      lvl_max <= '0;
    end else if (wr) begin
      if (idx[0]) begin
        lvl_max[wcls] <= pwdata[LVL_W-1:0];
      end else begin
        rate[wcls] <= pwdata[LVL_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx <= REG_LAST) begin
      if (idx[0]) begin
        prdata = APB_DW'(lvl_max[wcls]);
      end else begin
        prdata = APB_DW'(rate[wcls]);
      end
    end
  end

  // A write to either register of a class empties that class bucket.
  always_comb begin
    cfg.rate    = rate;
    cfg.lvl_max = lvl_max;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cfg.clr[c] = wr && (wcls == CLS_W'(c));
    end
  end

endmodule

// ===== hw/rtl/tbt_queue_mem.sv =====
module tbt_queue_mem
  import tbt_pkg::*;
#(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  wait_entry_t       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output wait_entry_t       rdata
);

  wait_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tbt_seq.sv =====
module tbt_seq
  import tbt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_W      = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  output logic              busy,
  output logic              rsp_valid,
  output rsp_t              rsp,
  input  cfg_t              cfg,
  output alu_op_t           alu_op,
  input  alu_res_t          alu_res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output wait_entry_t       mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  wait_entry_t       mem_rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REQ   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_SAT   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state;
  logic [CLS_W-1:0] cls;
  req_t             item;
  logic [NUM_CLASSES-1:0][LVL_W-1:0] lvl;
  logic [NUM_CLASSES-1:0][PTR_W-1:0] head;
  logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt;
  logic [LVL_W:0]   tmp;
  logic             hold_valid;
  rsp_t             hold;

  logic [PTR_W-1:0]  head_inc;
  logic [CNT_W:0]    slot_sum;
  logic [PTR_W-1:0]  slot;
  logic [ADDR_W-1:0] base;
  logic              rate_zero;
  logic              queue_full;
  logic [LVL_W-1:0]  diff;
  rsp_t              new_rsp;

  assign busy = (state != S_IDLE);

  assign head_inc = (head[cls] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[cls] + 1'b1;
  assign slot_sum = (CNT_W+1)'(head[cls]) + (CNT_W+1)'(cnt[cls]);
  assign slot     = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                  ? PTR_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
  assign base     = ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH);

  assign rate_zero  = (cfg.rate[cls] == '0);
  assign queue_full = (cnt[cls] == CNT_W'(QUEUE_DEPTH));
  assign diff       = alu_res.res[LVL_W-1:0];

  assign mem_waddr = base + ADDR_W'(slot);
  assign mem_wdata = '{tag: item.request_tag, tokens: item.tokens_wanted};
  assign mem_we    = (state == S_REQ) && !rate_zero && alu_res.borrow && !queue_full;
  // While a release is taken, the entry behind it is fetched for the next check.
  assign mem_raddr = (state == S_CHK) ? base + ADDR_W'(head_inc) : base + ADDR_W'(head[cls]);

  always_comb begin
    alu_op = '0;
    unique case (state)
      S_REQ: begin
        alu_op = '{a: {1'b0, lvl[cls]}, b: {1'b0, item.tokens_wanted}, sub: 1'b1};
      end
      S_ADD: begin
        alu_op = '{a: {1'b0, lvl[cls]}, b: {1'b0, cfg.rate[cls]}, sub: 1'b0};
      end
      S_SAT: begin
        alu_op = '{a: tmp, b: {1'b0, cfg.lvl_max[cls]}, sub: 1'b1};
      end
      S_CHK: begin
        alu_op = '{a: {1'b0, lvl[cls]}, b: {1'b0, mem_rdata.tokens}, sub: 1'b1};
      end
      default: begin
        alu_op = '0;
      end
    endcase
  end

  always_comb begin
    new_rsp              = '0;
    new_rsp.result_class = cls;
    new_rsp.last         = 1'b1;
    if (state == S_CHK) begin
      new_rsp.status      = ST_RELEASED;
      new_rsp.result_tag  = mem_rdata.tag;
      new_rsp.tokens_left = diff;
    end else begin
      new_rsp.result_tag  = item.request_tag;
      new_rsp.tokens_left = lvl[cls];
      priority if (rate_zero) begin
        new_rsp.status = ST_UNTHROTTLED;
      end else if (!alu_res.borrow) begin
        new_rsp.status      = ST_GRANTED;
        new_rsp.tokens_left = diff;
      end else if (queue_full) begin
        new_rsp.status = ST_SLIPPED;
      end else begin
        new_rsp.status = ST_QUEUED;
      end
    end
  end

  // Tick results go through a one-deep hold so the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cls        <= '0;
      lvl        <= '0;
      head       <= '0;
      cnt        <= '0;
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item <= req;
            if (req.command == CMD_TICK) begin
              cls   <= '0;
              state <= S_ADD;
            end else if (req.op_class != CLASS_INVALID) begin
              cls   <= req.op_class;
              state <= S_REQ;
            end
          end
        end
        S_REQ: begin
          rsp       <= new_rsp;
          rsp_valid <= 1'b1;
          if (!rate_zero) begin
            if (!alu_res.borrow) begin
              lvl[cls] <= diff;
            end else if (!queue_full) begin
              cnt[cls] <= cnt[cls] + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_ADD: begin
          tmp   <= alu_res.res;
          state <= S_SAT;
        end
        S_SAT: begin
          lvl[cls] <= alu_res.borrow ? tmp[LVL_W-1:0] : cfg.lvl_max[cls];
          if (cnt[cls] != '0) begin
            state <= S_CHK;
          end else if (cls == CLASS_LAST) begin
            state <= S_FLUSH;
          end else begin
            cls   <= cls + 1'b1;
            state <= S_ADD;
          end
        end
        S_CHK: begin
          if (!alu_res.borrow) begin
            lvl[cls]   <= diff;
            head[cls]  <= head_inc;
            cnt[cls]   <= cnt[cls] - 1'b1;
            hold       <= new_rsp;
            hold_valid <= 1'b1;
            if (hold_valid) begin
              rsp       <= '{status: hold.status, result_class: hold.result_class,
                             result_tag: hold.result_tag, tokens_left: hold.tokens_left,
                             last: 1'b0};
              rsp_valid <= 1'b1;
            end
          end
          if (alu_res.borrow || cnt[cls] == CNT_W'(1)) begin
            if (cls == CLASS_LAST) begin
              state <= S_FLUSH;
            end else begin
              cls   <= cls + 1'b1;
              state <= S_ADD;
            end
          end
        end
        S_FLUSH: begin
          if (hold_valid) begin
            rsp       <= '{status: hold.status, result_class: hold.result_class,
                           result_tag: hold.result_tag, tokens_left: hold.tokens_left,
                           last: 1'b1};
            rsp_valid <= 1'b1;
          end
          hold_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg.clr[c]) begin
          lvl[c] <= '0;
        end
      end
    end
  end

  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($past(state) == S_REQ || $past(state) == S_CHK || $past(state) == S_FLUSH))
    else $error("result strobe without a working state before it");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (cnt[cls] < CNT_W'(QUEUE_DEPTH)))
    else $error("queue write into a full class queue");

  a_flush_empties_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> !hold_valid)
    else $error("held result survives the end of a tick");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAT) |=> (lvl[$past(cls)] <= cfg.lvl_max[$past(cls)]))
    else $error("bucket level above its maximum after a tick");

endmodule

// ===== hw/rtl/token_bucket_throttle_with_queue.sv =====
// Request: start is registered into the request state, which registers the result and its strobe;
// busy is high in that state. A request for the invalid class gives no result. The adder is shared.
// Tick: per class an add and a saturate state, then, if entries wait, a check state that releases
// them in order until one does not fit or the queue empties; a flush state sends any held result.
// Results leave one per cycle with a strobe; the receiver cannot stall them.
// Synchronous active-high reset clears buckets, queue pointers and registers.
module token_bucket_throttle_with_queue
  import tbt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  output logic              busy,
  output logic              rsp_valid,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  cfg_t              cfg;
  alu_op_t           alu_op;
  alu_res_t          alu_res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  wait_entry_t       mem_wdata;
  wait_entry_t       mem_rdata;

  tbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbt_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  tbt_queue_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tbt_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg       (cfg),
    .alu_op    (alu_op),
    .alu_res   (alu_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
